// ----- rtl/core/agd_pkg.sv -----
// Shared constants, types and the exponential table for the split Gaussian evaluator.
package agd_pkg;

  // Fixed-point format of registers, input and result.
  localparam int FRAC_BITS      = 16;
  // Fraction bits of the exponent fed to the exponential product chain.
  localparam int EXP_TABLE_BITS = 10;
  // Table entry that holds exp(-1).
  localparam int TAB_TOP        = 14;

  localparam int DATA_W    = 32;
  // Scaled distance u is below 8.0, so it has three integer bits.
  localparam int UQ_W      = FRAC_BITS + 3;
  // Dividend of the scaling division: distance shifted left by the fraction bits.
  localparam int SCALE_N_W = DATA_W + FRAC_BITS;
  // Half of u squared, with FRAC_BITS fraction bits.
  localparam int T_W       = 2 * UQ_W - (FRAC_BITS + 1);
  // Requantization shift from FRAC_BITS to EXP_TABLE_BITS fraction bits.
  localparam int SH        = FRAC_BITS - EXP_TABLE_BITS;
  localparam int TQ_W      = EXP_TABLE_BITS + 6;
  localparam int EXP_STEPS = EXP_TABLE_BITS + 5;
  localparam int ACC_W     = DATA_W + 1;
  localparam int SUM_W     = DATA_W + 1;
  localparam int NUM_W     = 2 * DATA_W;
  // Dividend of the area division after the common shift is taken out.
  localparam int AREA_N_W  = NUM_W - FRAC_BITS;

  // round(sqrt(2/pi) * 2^32)
  localparam logic [DATA_W-1:0] SQRT_2_OVER_PI = 32'd3426888095;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_AMPLITUDE   = 2'd0,
    REG_CENTER      = 2'd1,
    REG_WIDTH_ABOVE = 2'd2,
    REG_WIDTH_BELOW = 2'd3
  } cfg_idx_e;

  // Result of the front end: scaled distance and flags.
  typedef struct packed {
    logic            valid;
    logic            bad;
    logic            zero;
    logic [UQ_W-1:0] u;
  } agd_scaled_t;

  // Numerator of the area division.
  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [NUM_W-1:0] num;
  } agd_num_t;

  // Final result before the output register.
  typedef struct packed {
    logic              valid;
    logic              bad;
    logic              sat;
    logic [DATA_W-1:0] q;
  } agd_result_t;

  // round(exp(-2^(k-14)) * 2^32) for k = 0 .. 18.
  function automatic logic [DATA_W-1:0] exp_neg_pow2(input int k);
    logic [DATA_W-1:0] c;
    unique case (k)
      0:       c = 32'd4294705160;
      1:       c = 32'd4294443040;
      2:       c = 32'd4293918848;
      3:       c = 32'd4292870656;
      4:       c = 32'd4290775039;
      5:       c = 32'd4286586875;
      6:       c = 32'd4278222805;
      7:       c = 32'd4261543595;
      8:       c = 32'd4228380000;
      9:       c = 32'd4162825044;
      10:      c = 32'd4034748382;
      11:      c = 32'd3790295335;
      12:      c = 32'd3344923893;
      13:      c = 32'd2605029347;
      14:      c = 32'd1580030169;
      15:      c = 32'd581260615;
      16:      c = 32'd78665070;
      17:      c = 32'd1440801;
      18:      c = 32'd483;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/asymmetric_gaussian_eval.sv -----
// Pipeline from the accepted request to valid_o: 19 scaling divider stages,
// 15 exponential product stages, 32 area divider stages and seven more registers.
// Throughput: one request per cycle; the whole pipeline advances on one enable,
// held only while the output register is full and stall_i is high.
// Reset: valid bits and registers return to amplitude 10.0, center 10.0, widths 4.0.
// Top level of the split Gaussian density evaluator.
module asymmetric_gaussian_eval (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] position_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] density_o,
  output logic        saturated_o,
  output logic        bad_width_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] amplitude_q;
  logic [31:0] center_q;
  logic [31:0] width_above_q;
  logic [31:0] width_below_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amplitude_q   <= 32'd655360;
      center_q      <= 32'd655360;
      width_above_q <= 32'd262144;
      width_below_q <= 32'd262144;
    end else if (cfg_we_i) begin
      unique case (agd_pkg::cfg_idx_e'(cfg_index_i))
        agd_pkg::REG_AMPLITUDE:   amplitude_q   <= cfg_data_i;
        agd_pkg::REG_CENTER:      center_q      <= cfg_data_i;
        agd_pkg::REG_WIDTH_ABOVE: width_above_q <= cfg_data_i;
        agd_pkg::REG_WIDTH_BELOW: width_below_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register can take a result.
  logic adv;
  logic valid_q;

  assign adv     = !valid_q || !stall_i;
  assign stall_o = !adv;

  logic [32:0] area;
  assign area = {1'b0, width_above_q} + {1'b0, width_below_q};

  agd_pkg::agd_scaled_t scaled;
  agd_pkg::agd_num_t    num;
  agd_pkg::agd_result_t res;

  agd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .valid_i       (valid_i),
    .position_i    (position_i),
    .center_i      (center_q),
    .width_above_i (width_above_q),
    .width_below_i (width_below_q),
    .out_o         (scaled)
  );

  agd_exp u_exp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_i        (scaled),
    .amplitude_i (amplitude_q),
    .out_o       (num)
  );

  agd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .in_i   (num),
    .area_i (area),
    .out_o  (res)
  );

  // Output register.
  logic [31:0] density_q;
  logic        sat_q;
  logic        bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      density_q <= res.q;
      sat_q     <= res.sat;
      bad_q     <= res.bad;
    end
  end

  assign valid_o     = valid_q;
  assign density_o   = density_q;
  assign saturated_o = sat_q;
  assign bad_width_o = bad_q;

`ifndef NO_ASSERTIONS
  // A zero width gives a zero density without the saturation flag.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && bad_width_o |-> density_o == '0 && !saturated_o)
    else $error("bad width result not zero");

  // A saturated result is all ones.
  a_sat_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && saturated_o |-> density_o == '1)
    else $error("saturated result not all ones");

  // The input stalls only while a held result waits on a stalled receiver.
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("stall without a held result");
`endif

endmodule

// ----- rtl/core/agd_front.sv -----
// Front end: width selection, distance and a pipelined restoring division for u.
module agd_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  logic [31:0]               position_i,
  input  logic [31:0]               center_i,
  input  logic [31:0]               width_above_i,
  input  logic [31:0]               width_below_i,
  output agd_pkg::agd_scaled_t      out_o
);

  localparam int UQ_W = agd_pkg::UQ_W;
  localparam int NW   = agd_pkg::SCALE_N_W;

  logic              v_q    [UQ_W+1];
  logic              bad_q  [UQ_W+1];
  logic              zero_q [UQ_W+1];
  logic [31:0]       w_q    [UQ_W+1];
  logic [31:0]       rem_q  [UQ_W+1];
  logic [UQ_W-1:0]   low_q  [UQ_W+1];
  logic [UQ_W-1:0]   quo_q  [UQ_W+1];

  logic              above;
  logic [31:0]       w_d;
  logic [31:0]       dist_d;
  logic [NW-1:0]     num_d;
  logic              over_d;

  // Pick the width and the distance on the side of the center.
  assign above  = position_i > center_i;
  assign w_d    = above ? width_above_i : width_below_i;
  assign dist_d = above ? (position_i - center_i) : (center_i - position_i);
  assign num_d  = {dist_d, {agd_pkg::FRAC_BITS{1'b0}}};
  // u reaches 8.0 exactly when the distance is at least eight widths.
  assign over_d = {3'b000, dist_d} >= {w_d, 3'b000};

  // Entry stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (adv_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      bad_q[0]  <= (w_d == '0);
      zero_q[0] <= over_d;
      w_q[0]    <= w_d;
      rem_q[0]  <= 32'(num_d[NW-1:UQ_W]);
      low_q[0]  <= num_d[UQ_W-1:0];
      quo_q[0]  <= '0;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar s = 0; s < UQ_W; s++) begin : g_div
    logic [32:0] trial;
    logic        take;

    assign trial = {rem_q[s], low_q[s][UQ_W-1]};
    assign take  = trial >= {1'b0, w_q[s]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (adv_i) begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s+1]  <= take ? 32'(trial - {1'b0, w_q[s]}) : trial[31:0];
        low_q[s+1]  <= {low_q[s][UQ_W-2:0], 1'b0};
        quo_q[s+1]  <= {quo_q[s][UQ_W-2:0], take};
        w_q[s+1]    <= w_q[s];
        bad_q[s+1]  <= bad_q[s];
        zero_q[s+1] <= zero_q[s];
      end
    end
  end

  assign out_o.valid = v_q[UQ_W];
  assign out_o.bad   = bad_q[UQ_W];
  assign out_o.zero  = zero_q[UQ_W];
  assign out_o.u     = quo_q[UQ_W];

endmodule

// ----- rtl/core/agd_exp.sv -----
// Exponential stage: square, requantize, product chain over exponent bits, scale.
module agd_exp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  agd_pkg::agd_scaled_t  in_i,
  input  logic [31:0]           amplitude_i,
  output agd_pkg::agd_num_t     out_o
);

  localparam int UQ_W  = agd_pkg::UQ_W;
  localparam int T_W   = agd_pkg::T_W;
  localparam int TQ_W  = agd_pkg::TQ_W;
  localparam int STEPS = agd_pkg::EXP_STEPS;
  localparam int ACC_W = agd_pkg::ACC_W;
  localparam int ETB   = agd_pkg::EXP_TABLE_BITS;

  // Square stage.
  logic                v_a_q;
  logic                bad_a_q;
  logic                zero_a_q;
  logic [2*UQ_W-1:0]   sq_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
    end else if (adv_i) begin
      v_a_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      bad_a_q  <= in_i.bad;
      zero_a_q <= in_i.zero;
      sq_a_q   <= in_i.u * in_i.u;
    end
  end

  // Requantize half of u squared to the exponent format.
  logic [T_W-1:0]  t_d;
  logic [TQ_W-1:0] tq_d;

  assign t_d = sq_a_q[2*UQ_W-1:agd_pkg::FRAC_BITS+1];

  if (agd_pkg::SH > 0) begin : g_narrow
    localparam int RSH = agd_pkg::SH;
    logic [T_W:0] rounded;
    assign rounded = {1'b0, t_d} + (T_W+1)'(1 << (RSH - 1));
    assign tq_d    = TQ_W'(rounded >> RSH);
  end else begin : g_widen
    localparam int LSH = -agd_pkg::SH;
    assign tq_d = TQ_W'(t_d) << LSH;
  end

  logic              vs_q   [STEPS+1];
  logic              bad_q  [STEPS+1];
  logic              zero_q [STEPS+1];
  logic [TQ_W-1:0]   tq_q   [STEPS+1];
  logic [ACC_W-1:0]  acc_q  [STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q[0] <= 1'b0;
    end else if (adv_i) begin
      vs_q[0] <= v_a_q;
    end
  end

  // An exponent of 32 or more gives zero.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      bad_q[0]  <= bad_a_q;
      zero_q[0] <= zero_a_q ||
                   (tq_d[TQ_W-1:ETB] >= (TQ_W-ETB)'(32));
      tq_q[0]   <= tq_d;
      acc_q[0]  <= ACC_W'(1) << 32;
    end
  end

  // One exponent bit per stage, lowest first, one rounded multiply each.
  for (genvar k = 0; k < STEPS; k++) begin : g_chain
    localparam int IDX = k + agd_pkg::TAB_TOP - ETB;
    localparam logic [31:0] C = agd_pkg::exp_neg_pow2(IDX);
    logic [ACC_W+31:0] prod;
    logic [ACC_W+31:0] rnd;

    assign prod = acc_q[k] * C;
    assign rnd  = prod + (ACC_W+32)'(64'h8000_0000);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[k+1] <= 1'b0;
      end else if (adv_i) begin
        vs_q[k+1] <= vs_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        acc_q[k+1]  <= tq_q[k][k] ? ACC_W'(rnd >> 32) : acc_q[k];
        tq_q[k+1]   <= tq_q[k];
        bad_q[k+1]  <= bad_q[k];
        zero_q[k+1] <= zero_q[k];
      end
    end
  end

  // Multiply by sqrt(2/pi).
  logic              v_k_q;
  logic              bad_k_q;
  logic [31:0]       m_k_q;
  logic [ACC_W+31:0] mprod;
  logic [ACC_W+31:0] mrnd;

  assign mprod = acc_q[STEPS] * agd_pkg::SQRT_2_OVER_PI;
  assign mrnd  = mprod + (ACC_W+32)'(64'h8000_0000);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_k_q <= 1'b0;
    end else if (adv_i) begin
      v_k_q <= vs_q[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      bad_k_q <= bad_q[STEPS];
      m_k_q   <= zero_q[STEPS] ? 32'd0 : 32'(mrnd >> 32);
    end
  end

  // Multiply by the amplitude.
  logic        v_n_q;
  logic        bad_n_q;
  logic [63:0] num_n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_n_q <= 1'b0;
    end else if (adv_i) begin
      v_n_q <= v_k_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      bad_n_q <= bad_k_q;
      num_n_q <= amplitude_i * m_k_q;
    end
  end

  assign out_o.valid = v_n_q;
  assign out_o.bad   = bad_n_q;
  assign out_o.num   = num_n_q;

endmodule

// ----- rtl/core/agd_back.sv -----
// Back end: pipelined restoring division by the area, saturation and flags.
module agd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  agd_pkg::agd_num_t     in_i,
  input  logic [32:0]           area_i,
  output agd_pkg::agd_result_t  out_o
);

  localparam int NW = agd_pkg::AREA_N_W;
  localparam int QW = agd_pkg::DATA_W;

  logic            v_q   [QW+1];
  logic            bad_q [QW+1];
  logic            sat_q [QW+1];
  logic [32:0]     rem_q [QW+1];
  logic [QW-1:0]   low_q [QW+1];
  logic [QW-1:0]   quo_q [QW+1];

  logic [NW-1:0]   n_d;

  assign n_d = in_i.num[agd_pkg::NUM_W-1:agd_pkg::FRAC_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (adv_i) begin
      v_q[0] <= in_i.valid;
    end
  end

  // The quotient overflows when the upper dividend part reaches the divisor.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      bad_q[0] <= in_i.bad;
      sat_q[0] <= 33'(n_d[NW-1:QW]) >= area_i;
      rem_q[0] <= 33'(n_d[NW-1:QW]);
      low_q[0] <= n_d[QW-1:0];
      quo_q[0] <= '0;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_div
    logic [33:0] trial;
    logic        take;

    assign trial = {rem_q[s], low_q[s][QW-1]};
    assign take  = trial >= {1'b0, area_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (adv_i) begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s+1] <= take ? 33'(trial - {1'b0, area_i}) : trial[32:0];
        low_q[s+1] <= {low_q[s][QW-2:0], 1'b0};
        quo_q[s+1] <= {quo_q[s][QW-2:0], take};
        bad_q[s+1] <= bad_q[s];
        sat_q[s+1] <= sat_q[s];
      end
    end
  end

  // A zero width wins over saturation.
  assign out_o.valid = v_q[QW];
  assign out_o.bad   = bad_q[QW];
  assign out_o.sat   = sat_q[QW] && !bad_q[QW];
  assign out_o.q     = bad_q[QW] ? '0 : (sat_q[QW] ? '1 : quo_q[QW]);

endmodule

// ----- tb/agd_checker.sv -----
// Checker for the split Gaussian evaluator: predicts each density and compares results.
`timescale 1ns / 100ps

module agd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic        stall_o,
  input  logic [31:0] position_i,
  input  logic        valid_o,
  input  logic        stall_i,
  input  logic [31:0] density_o,
  input  logic        saturated_o,
  input  logic        bad_width_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [31:0] density;
    logic        sat;
    logic        bad;
  } density_t;

  // round(exp(-2^(k-14)) * 2^32)
  localparam logic [31:0] EXP_WEIGHTS [19] = '{
    32'd4294705160, 32'd4294443040, 32'd4293918848, 32'd4292870656,
    32'd4290775039, 32'd4286586875, 32'd4278222805, 32'd4261543595,
    32'd4228380000, 32'd4162825044, 32'd4034748382, 32'd3790295335,
    32'd3344923893, 32'd2605029347, 32'd1580030169, 32'd581260615,
    32'd78665070, 32'd1440801, 32'd483};
  localparam logic [63:0] KNORM = 64'd3426888095;
  localparam int FB  = agd_pkg::FRAC_BITS;
  localparam int ETB = agd_pkg::EXP_TABLE_BITS;

  logic [63:0] amp_q, ctr_q, wa_q, wb_q;
  density_t    expected_q[$];
  int          fails;

  // Bit-exact prediction of one density evaluation.
  function automatic density_t eval_density(logic [63:0] x);
    density_t    r;
    logic [63:0] w, d, u, t, tq, e, m, num, dvs, q;
    int          idx;
    r = '0;
    w = (x > ctr_q) ? wa_q : wb_q;
    d = (x > ctr_q) ? x - ctr_q : ctr_q - x;
    if (w == 0) begin
      r.bad = 1'b1;
      return r;
    end
    u = (d << FB) / w;
    e = 0;
    if (u < (64'd8 << FB)) begin
      t  = (u * u) >> (FB + 1);
      tq = (t + (64'd1 << (FB - ETB - 1))) >> (FB - ETB);
      if ((tq >> ETB) < 32) begin
        e = 64'd1 << 32;
        for (int i = 0; i < ETB + 5; i++) begin
          idx = i + 14 - ETB;
          if (tq[i] && idx >= 0 && idx <= 18)
            e = (e * EXP_WEIGHTS[idx] + (64'd1 << 31)) >> 32;
        end
      end
    end
    m   = (e * KNORM + (64'd1 << 31)) >> 32;
    num = amp_q * m;
    dvs = (wa_q + wb_q) << (32 - FB);
    q   = num / dvs;
    if (q > 64'hFFFF_FFFF) begin
      r.density = '1;
      r.sat     = 1'b1;
    end else begin
      r.density = q[31:0];
    end
    return r;
  endfunction

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  // Track registers, queue predictions and compare results.
  always @(posedge clk_i or negedge rst_ni) begin
    density_t exp_r;
    int       errs;
    errs = 0;
    if (!rst_ni) begin
      amp_q <= 64'd655360;
      ctr_q <= 64'd655360;
      wa_q  <= 64'd262144;
      wb_q  <= 64'd262144;
      expected_q.delete();
      fails <= 0;
    end else begin
      if (valid_i && !stall_o) expected_q.push_back(eval_density({32'd0, position_i}));
      if (valid_o && !stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding");
          errs++;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.density !== density_o) begin
            $error("density: expected %h actual %h", exp_r.density, density_o);
            errs++;
          end
          if (exp_r.sat !== saturated_o) begin
            $error("saturated: expected %b actual %b", exp_r.sat, saturated_o);
            errs++;
          end
          if (exp_r.bad !== bad_width_o) begin
            $error("bad_width: expected %b actual %b", exp_r.bad, bad_width_o);
            errs++;
          end
        end
      end
      if (errs != 0) fails <= fails + errs;
      if (cfg_we_i) begin
        unique case (agd_pkg::cfg_idx_e'(cfg_index_i))
          agd_pkg::REG_AMPLITUDE:   amp_q <= {32'd0, cfg_data_i};
          agd_pkg::REG_CENTER:      ctr_q <= {32'd0, cfg_data_i};
          agd_pkg::REG_WIDTH_ABOVE: wa_q  <= {32'd0, cfg_data_i};
          agd_pkg::REG_WIDTH_BELOW: wb_q  <= {32'd0, cfg_data_i};
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- tb/tb.sv -----
// Testbench top: stimulus, configuration phases and verdict for the split Gaussian evaluator.
`timescale 1ns / 100ps

module tb;

  localparam int LATENCY     = 73;
  localparam int IDLE_LIMIT  = 5000;
  localparam int RAND_ITEMS  = 100;

  logic        clk_i, rst_ni;
  logic        valid_i, stall_o, valid_o, stall_i;
  logic [31:0] position_i, density_o;
  logic        saturated_o, bad_width_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  int          fail_count, pending;
  int          idle_cycles;
  logic        hold_off;
  logic [31:0] ctr_now;

  asymmetric_gaussian_eval u_top (.*);

  agd_checker u_checker (
    .clk_i, .rst_ni, .valid_i, .stall_o, .position_i, .valid_o, .stall_i,
    .density_o, .saturated_o, .bad_width_o, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Clock.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver stall pattern, with one long hold-off on request.
  initial begin
    stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off) stall_i <= 1'b1;
      else case ($urandom_range(3))
        0:       stall_i <= ($urandom_range(1) == 1);
        1:       stall_i <= ($urandom_range(7) == 0);
        default: stall_i <= 1'b0;
      endcase
    end
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one request and wait for acceptance; random gap before it sometimes.
  task automatic send_position(logic [31:0] pos, bit bursty);
    int gap;
    gap = (bursty && $urandom_range(5) == 0) ? int'($urandom_range(6, 1)) : 0;
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i    <= 1'b1;
    position_i <= pos;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
  endtask

  task automatic go_idle();
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  // One register write, after which the write enable is set low again.
  task automatic write_reg(agd_pkg::cfg_idx_e idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    if (idx == agd_pkg::REG_CENTER) ctr_now = val;
  endtask

  function automatic logic [31:0] rand_width();
    case ($urandom_range(4))
      0:       return $urandom_range(32'h0003_0000, 32'h0006_0000);
      1:       return $urandom();
      2:       return $urandom_range(32'h100);
      default: return $urandom_range(32'h0000_4000, 32'h0010_0000);
    endcase
  endfunction

  // Positions mostly near the center so the exponential is exercised.
  function automatic logic [31:0] rand_position();
    logic [31:0] off;
    off = $urandom_range(32'h0020_0000);
    case ($urandom_range(3))
      0:       return $urandom();
      1:       return ctr_now - off;
      default: return ctr_now + off;
    endcase
  endfunction

  initial begin
    rst_ni = 1'b0; valid_i = 1'b0; position_i = '0; hold_off = 1'b0;
    cfg_we_i = 1'b0; cfg_index_i = agd_pkg::REG_AMPLITUDE; cfg_data_i = '0;
    idle_cycles = 0; ctr_now = 32'd655360;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, extremes, the center point and the far tail.
    send_position(32'd0, 0);
    send_position(32'hFFFF_FFFF, 0);
    send_position(32'd655360, 0);
    send_position(32'd655361, 0);
    send_position(32'd655359, 0);
    send_position(32'd655360 + 32'h0008_0000, 0);
    send_position(32'd655360 + 32'h0020_0000, 0);
    send_position(32'hAAAA_AAAA, 0);
    send_position(32'h5555_5555, 0);
    go_idle();

    // Zero widths on each side, and saturation from a huge amplitude.
    write_reg(agd_pkg::REG_WIDTH_BELOW, 32'd0);
    write_reg(agd_pkg::REG_AMPLITUDE, 32'hFFFF_FFFF);
    send_position(32'd655360, 0);
    send_position(32'd0, 0);
    send_position(32'd655360 + 32'h0001_0000, 0);
    send_position(32'd655361, 0);
    go_idle();
    write_reg(agd_pkg::REG_WIDTH_BELOW, 32'd1);
    write_reg(agd_pkg::REG_WIDTH_ABOVE, 32'd0);
    write_reg(agd_pkg::REG_CENTER, 32'hFFFF_FFFF);
    send_position(32'hFFFF_FFFF, 0);
    send_position(32'hFFFF_FFFE, 0);
    send_position(32'd0, 0);
    go_idle();
    write_reg(agd_pkg::REG_CENTER, 32'd0);
    write_reg(agd_pkg::REG_WIDTH_ABOVE, 32'hFFFF_FFFF);
    write_reg(agd_pkg::REG_WIDTH_BELOW, 32'hFFFF_FFFF);
    write_reg(agd_pkg::REG_AMPLITUDE, 32'd0);
    send_position(32'd0, 0);
    send_position(32'hFFFF_FFFF, 0);
    go_idle();

    // Random phases with fresh settings; one phase holds the receiver off.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(agd_pkg::REG_AMPLITUDE, ph == 5 ? 32'hFFFF_FFFF : $urandom());
      write_reg(agd_pkg::REG_CENTER, $urandom());
      write_reg(agd_pkg::REG_WIDTH_ABOVE, rand_width());
      write_reg(agd_pkg::REG_WIDTH_BELOW, rand_width());
      if (ph == 2) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < RAND_ITEMS; n++) send_position(rand_position(), 1);
      go_idle();
    end

    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
